>>> rtl/tea_ctr_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the tea counter-mode stream cipher
// no dependencies; used by every module of the block

package tea_ctr_pkg;

   // tea round constant
   localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

   // configuration register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_ZERO   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_ONE    = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_TWO    = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEY_WORD_THREE  = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONCE_LOW_WORD  = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_NONCE_HIGH_WORD = 3'd5;

   // 128-bit key as four words
   typedef struct packed {
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] k2;
      logic [31:0] k3;
   } key_type;

   // one item travelling down the round chain with its cipher block
   typedef struct packed {
      logic [31:0] w0;
      logic [31:0] w1;
      logic [7:0]  data;
      logic [2:0]  pos;
   } lane_type;

   // block counter and byte position handed to the chain entry
   typedef struct packed {
      logic [31:0] ctr;
      logic [2:0]  pos;
   } seq_type;

endpackage

>>> rtl/tea_ctr_round_cell.sv
`timescale 1ns / 1ps
// one half round of tea as a pipeline cell of the round chain
// depends on tea_ctr_pkg for the lane and key types

module tea_ctr_round_cell #(
   parameter logic [31:0] ROUND_SUM = 32'h9E37_79B9,
   parameter bit          UPPER     = 1'b0
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                valid_in,
   input  tea_ctr_pkg::lane_type lane_in,
   input  tea_ctr_pkg::key_type  key,
   output logic                valid_out,
   output tea_ctr_pkg::lane_type lane_out
);

   logic                  valid_ff;
   tea_ctr_pkg::lane_type lane_ff;
   tea_ctr_pkg::lane_type lane_in_next;
   logic [31:0]           src_word;
   logic [31:0]           mix_word;

   // half round: lower cell updates w0 from w1, upper cell updates w1 from w0
   always_comb begin
      lane_in_next = lane_in;
      if (UPPER) begin
         src_word = lane_in.w0;
         mix_word = ((src_word << 4) + key.k2) ^ (src_word + ROUND_SUM)
                    ^ ((src_word >> 5) + key.k3);
         lane_in_next.w1 = lane_in.w1 + mix_word;
      end else begin
         src_word = lane_in.w1;
         mix_word = ((src_word << 4) + key.k0) ^ (src_word + ROUND_SUM)
                    ^ ((src_word >> 5) + key.k1);
         lane_in_next.w0 = lane_in.w0 + mix_word;
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= valid_in;
      end
   end

   // payload stage
   always_ff @(posedge clock) begin
      if (load) begin
         lane_ff <= lane_in_next;
      end
   end

   assign valid_out = valid_ff;
   assign lane_out  = lane_ff;

endmodule

>>> rtl/tea_ctr_seq.sv
`timescale 1ns / 1ps
// block counter and byte position tracking for accepted items
// depends on tea_ctr_pkg for the sequence type

module tea_ctr_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic                 last_byte,
   output tea_ctr_pkg::seq_type seq
);

   logic [31:0] next_ff;
   logic [31:0] next_in;
   logic [31:0] cur_ff;
   logic [31:0] cur_in;
   logic [2:0]  pos_ff;
   logic [2:0]  pos_in;
   logic        block_start;

   assign block_start = (pos_ff == 3'd0);

   // counter of the block an item belongs to
   assign seq.ctr = block_start ? next_ff : cur_ff;
   assign seq.pos = pos_ff;

   // advance on each accepted item, restart after the end of a message
   always_comb begin
      next_in = next_ff;
      cur_in  = cur_ff;
      pos_in  = pos_ff;
      if (accept) begin
         if (block_start) begin
            cur_in  = next_ff;
            next_in = next_ff + 32'd1;
         end
         if (last_byte) begin
            next_in = 32'd0;
            pos_in  = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_ff <= 32'd0;
         cur_ff  <= 32'd0;
         pos_ff  <= 3'd0;
      end else begin
         next_ff <= next_in;
         cur_ff  <= cur_in;
         pos_ff  <= pos_in;
      end
   end

`ifndef SYNTHESIS
   // end of message brings position and counter back to the start
   assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> pos_ff == 3'd0 && next_ff == 32'd0)
      else $error("position or counter not cleared after last item");

   // a block start inside a message moves the counter on by one
   assert property (@(posedge clock) disable iff (reset)
      accept && !last_byte && block_start |=> next_ff == $past(next_ff) + 32'd1)
      else $error("block counter did not advance at block start");
`endif

endmodule

>>> rtl/tea_ctr_stream_cipher.sv
`timescale 1ns / 1ps
// top level of the tea counter-mode byte stream cipher
// depends on tea_ctr_pkg, tea_ctr_seq and tea_ctr_round_cell

// Takes one byte per cycle and returns one byte per cycle while neither side
// stalls. Every item carries its own counter block down a chain of
// 2*ROUND_COUNT half-round cells; the enciphered block of the first byte of
// each keystream block is kept at the chain exit and the other bytes of that
// block use the kept keystream. Results pass from the last cell through the
// output buffer. A two-entry output buffer keeps input accepted while a
// result waits; when that buffer is full the whole chain holds and the input
// is stalled. Configuration writes act on the registers at once and are
// meant to be made only while no item is in flight; a keystream block that
// has already started keeps its keystream up to its last byte.

module tea_ctr_stream_cipher #(
   parameter int unsigned ROUND_COUNT = 32
) (
   input  logic        clock,
   input  logic        reset,
   // input items
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_result_byte,
   // configuration
   input  logic        csr_write_enable,
   input  logic [tea_ctr_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [31:0] csr_write_data
);

   localparam int unsigned CELL_COUNT = 2 * ROUND_COUNT;

   tea_ctr_pkg::key_type  key_ff;
   logic [31:0]           nonce_low_ff;
   logic [31:0]           nonce_high_ff;

   tea_ctr_pkg::seq_type  seq;
   tea_ctr_pkg::lane_type entry_lane;
   tea_ctr_pkg::lane_type cell_lane [CELL_COUNT];
   logic [CELL_COUNT-1:0] cell_valid;

   logic                  pipe_en;
   logic                  req_accept;
   logic                  push;
   logic                  pop;
   logic [1:0]            skid_count_ff;
   logic [1:0]            skid_count_in;
   logic [7:0]            skid_ff [2];
   logic [7:0]            skid_in [2];
   logic                  wr_slot;
   logic [63:0]           ks_block;
   logic [63:0]           ks_hold_ff;
   logic [63:0]           ks_cur;
   logic                  ks_start;
   logic [63:0]           ks_shifted;
   logic [7:0]            out_byte;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         nonce_low_ff  <= 32'd0;
         nonce_high_ff <= 32'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            tea_ctr_pkg::CSR_KEY_WORD_ZERO:   key_ff.k0     <= csr_write_data;
            tea_ctr_pkg::CSR_KEY_WORD_ONE:    key_ff.k1     <= csr_write_data;
            tea_ctr_pkg::CSR_KEY_WORD_TWO:    key_ff.k2     <= csr_write_data;
            tea_ctr_pkg::CSR_KEY_WORD_THREE:  key_ff.k3     <= csr_write_data;
            tea_ctr_pkg::CSR_NONCE_LOW_WORD:  nonce_low_ff  <= csr_write_data;
            tea_ctr_pkg::CSR_NONCE_HIGH_WORD: nonce_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // chain moves while the output buffer has room
   assign pipe_en    = (skid_count_ff != 2'd2);
   assign req_stall  = !pipe_en;
   assign req_accept = req_valid && pipe_en;

   // block counter and byte position
   tea_ctr_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .last_byte (req_last_byte),
      .seq       (seq)
   );

   // counter block formed at the chain entry
   always_comb begin
      entry_lane.w0   = nonce_low_ff ^ seq.ctr;
      entry_lane.w1   = nonce_high_ff;
      entry_lane.data = req_data_byte;
      entry_lane.pos  = seq.pos;
   end

   // chain of half-round cells
   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      localparam logic [31:0] ROUND_SUM =
         32'(64'(tea_ctr_pkg::TEA_DELTA) * 64'(c / 2 + 1));
      if (c == 0) begin : g_first
         tea_ctr_round_cell #(
            .ROUND_SUM (ROUND_SUM),
            .UPPER     (1'b0)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (pipe_en),
            .valid_in  (req_valid),
            .lane_in   (entry_lane),
            .key       (key_ff),
            .valid_out (cell_valid[c]),
            .lane_out  (cell_lane[c])
         );
      end else begin : g_next
         tea_ctr_round_cell #(
            .ROUND_SUM (ROUND_SUM),
            .UPPER     (1'(c % 2))
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .load      (pipe_en),
            .valid_in  (cell_valid[c-1]),
            .lane_in   (cell_lane[c-1]),
            .key       (key_ff),
            .valid_out (cell_valid[c]),
            .lane_out  (cell_lane[c])
         );
      end
   end

   // first byte of a block takes the fresh keystream, the rest reuse the kept one
   assign ks_block = {cell_lane[CELL_COUNT-1].w1, cell_lane[CELL_COUNT-1].w0};
   assign ks_start = (cell_lane[CELL_COUNT-1].pos == 3'd0);
   assign ks_cur   = ks_start ? ks_block : ks_hold_ff;

   always_ff @(posedge clock) begin
      if (push && ks_start) begin
         ks_hold_ff <= ks_block;
      end
   end

   // keystream byte select, little-endian over the enciphered block
   assign ks_shifted = ks_cur >> {cell_lane[CELL_COUNT-1].pos, 3'b000};
   assign out_byte   = cell_lane[CELL_COUNT-1].data ^ ks_shifted[7:0];

   // two-entry output buffer
   assign push    = pipe_en && cell_valid[CELL_COUNT-1];
   assign pop     = rsp_valid && !rsp_stall;
   assign wr_slot = 1'(skid_count_ff - {1'b0, pop});

   always_comb begin
      skid_in[0] = skid_ff[0];
      skid_in[1] = skid_ff[1];
      if (pop) begin
         skid_in[0] = skid_ff[1];
      end
      if (push) begin
         skid_in[wr_slot] = out_byte;
      end
      skid_count_in = skid_count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_count_ff <= 2'd0;
      end else begin
         skid_count_ff <= skid_count_in;
      end
   end

   always_ff @(posedge clock) begin
      skid_ff[0] <= skid_in[0];
      skid_ff[1] <= skid_in[1];
   end

   assign rsp_valid       = (skid_count_ff != 2'd0);
   assign rsp_result_byte = skid_ff[0];

`ifndef SYNTHESIS
   // output buffer never overfills
   assert property (@(posedge clock) disable iff (reset)
      skid_count_ff != 2'd3)
      else $error("output buffer overflow");

   // a held chain keeps every item in place
   assert property (@(posedge clock) disable iff (reset)
      !pipe_en |=> $stable(cell_valid))
      else $error("round chain moved while held");

   // nothing comes out straight after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid && cell_valid == '0)
      else $error("items present after reset");
`endif

endmodule
